FILE: rtl/eml_pkg.sv
`timescale 1ns / 1ps

package eml_pkg;

	// Field widths fixed by the word formats.
	localparam int SLOT_W = 3;
	localparam int BLK_W = 32;

	// Default table depth.
	localparam int EXTENT_SLOTS_DEF = 8;

	// Command codes carried in the request word.
	typedef enum logic [0:0] {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	// Request word: one table write or one lookup.
	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  extent_start;
		logic [BLK_W-1:0]  extent_length;
		logic [BLK_W-1:0]  logical_index;
	} req_t;

	// Response word: one per lookup.
	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] physical_block;
	} rsp_t;

	// Outcome of one walk step over a single extent.
	typedef struct packed {
		logic             hit;
		logic [BLK_W-1:0] rem_next;
		logic [BLK_W-1:0] phys;
	} step_res_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/eml_step.sv
`timescale 1ns / 1ps

// One step of the extent walk: compare the remaining index against one
// extent, and either translate it or subtract the extent length.
module eml_step (
	input  logic                      entry_used,
	input  logic [eml_pkg::BLK_W-1:0] rem,
	input  logic [eml_pkg::BLK_W-1:0] len,
	input  logic [eml_pkg::BLK_W-1:0] start,
	output eml_pkg::step_res_t        res
);
	import eml_pkg::*;

	logic used;

	// An extent counts only if its slot was written with a nonzero length.
	assign used = entry_used && (len != '0);

	always_comb begin
		res.hit = used && (rem < len);
		res.rem_next = used ? (rem - len) : rem;
		res.phys = start + rem;
	end

endmodule

FILE: rtl/extent_map_lookup.sv
`timescale 1ns / 1ps
// A write word leaves the sequencer idle; the next word is accepted in the following cycle.
// A lookup walks the table one slot per cycle through a single compare and subtract unit.
// After a lookup is accepted, the sequencer primes the memory read of the first slot, then walks
// the slots up to a hit or the last slot and loads the result register, then loads the response
// register. The next word is taken only after that load, so a lookup holds the input until then,
// and longer while an earlier response is still waiting.
// Reset is asynchronous and marks every slot unused; table contents need no clearing.
module extent_map_lookup #(
	parameter int EXTENT_SLOTS = eml_pkg::EXTENT_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  eml_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output eml_pkg::rsp_t rsp
);
	import eml_pkg::*;

	localparam int IDX_W = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EXTENT_SLOTS - 1);
	localparam int ENTRY_W = 2 * BLK_W;

	state_t state_q, state_nxt;

	// Table memory: start in the upper half, length in the lower half.
	logic [ENTRY_W-1:0]      ext_mem [EXTENT_SLOTS];
	logic [EXTENT_SLOTS-1:0] used_q;

	logic [IDX_W-1:0]   ptr_q;
	logic [ENTRY_W-1:0] entry_s1;
	logic               used_s1;
	logic [IDX_W-1:0]   slot_s1;
	logic [BLK_W-1:0]   rem_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               req_fire;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [SLOT_W+IDX_W-1:0] slot_ext;
	logic               walk_rd;
	logic               res_load;
	logic               rsp_load;
	logic               walk_end;
	step_res_t          step;

	assign req_fire = req_valid && req_ready;
	assign slot_ext = (SLOT_W + IDX_W)'(req.slot);
	assign wr_addr = slot_ext[IDX_W-1:0];
	assign wr_en = req_fire && (req.cmd == CMD_WRITE) && (32'(req.slot) < EXTENT_SLOTS);

	// Shared compare and subtract unit.
	eml_step u_step (
		.entry_used (used_s1),
		.rem        (rem_q),
		.len        (entry_s1[BLK_W-1:0]),
		.start      (entry_s1[ENTRY_W-1:BLK_W]),
		.res        (step)
	);

	assign walk_end = step.hit || (slot_s1 == LAST_IDX);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && (req.cmd == CMD_LOOKUP)) begin
					state_nxt = ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (walk_end) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_ready = 1'b0;
		walk_rd = 1'b0;
		res_load = 1'b0;
		rsp_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_PRIME: begin
				walk_rd = 1'b1;
			end
			ST_WALK: begin
				walk_rd = 1'b1;
				res_load = walk_end;
			end
			ST_DONE: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				used_q[wr_addr] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ext_mem[wr_addr] <= {req.extent_start, req.extent_length};
		end
		if (walk_rd) begin
			entry_s1 <= ext_mem[ptr_q];
		end
	end

	// Walk datapath: read pointer, remainder and result registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ptr_q <= '0;
			rem_q <= req.logical_index;
		end else if (walk_rd) begin
			if (ptr_q != LAST_IDX) begin
				ptr_q <= ptr_q + 1'b1;
			end
			used_s1 <= used_q[ptr_q];
			slot_s1 <= ptr_q;
			if (state_q == ST_WALK) begin
				rem_q <= step.rem_next;
			end
		end
		if (res_load) begin
			res_q.found <= step.hit;
			res_q.physical_block <= step.hit ? step.phys : '0;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// A response that reports a miss carries a zero block number.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.physical_block == '0)
		else $error("miss response with nonzero block");

	// An accepted lookup starts the walk in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.cmd == CMD_LOOKUP |=> state_q == ST_PRIME)
		else $error("lookup did not start walk");

	// The walk never runs past the last slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && slot_s1 == LAST_IDX |=> state_q == ST_DONE)
		else $error("walk ran past last slot");

	// No new word is taken while a lookup is priming or walking.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK || state_q == ST_PRIME |-> !req_ready)
		else $error("request accepted during walk");

endmodule
